/* design/hcl_pkg.sv */
// ----------------------------------------------------------------------------
// hcl_pkg
// Shared constants and types for the trilinear color lookup pipeline.
// ----------------------------------------------------------------------------
package hcl_pkg;

    // Default parameter values.
    localparam int MAX_LEVEL_DEF     = 8;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed field widths.
    localparam int ADDR_BITS      = 18;
    localparam int BYTE_BITS      = 8;
    localparam int ENTRY_BITS     = 3 * BYTE_BITS;
    localparam int LEVEL_BITS     = 4;
    localparam int LEVEL_EXT_BITS = 5;
    localparam int LEVEL_RESET    = 8;
    localparam int LEVEL_MIN      = 2;
    localparam int CORNERS        = 8;

    // Transaction kinds on the input channel.
    typedef enum logic {
        MODE_WRITE = 1'b0,
        MODE_PIXEL = 1'b1
    } mode_t;

    // Control that travels with each pipeline slot.
    typedef struct packed {
        logic pixel;   // slot carries a pixel that yields a result
        logic write;   // slot carries an in-range table write
    } hcl_ctl_t;

endpackage

/* design/hcl_if.sv */
// ----------------------------------------------------------------------------
// hcl_in_if / hcl_out_if
// Valid/ready channels for table writes and pixels in, colors out.
// ----------------------------------------------------------------------------
interface hcl_in_if
    import hcl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) ();
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [ADDR_BITS-1:0]            entry_address;
    logic [BYTE_BITS-1:0]            entry_red;
    logic [BYTE_BITS-1:0]            entry_green;
    logic [BYTE_BITS-1:0]            entry_blue;
    logic signed [FRACTION_BITS+1:0] pixel_red;
    logic signed [FRACTION_BITS+1:0] pixel_green;
    logic signed [FRACTION_BITS+1:0] pixel_blue;

    modport source (
        output valid, mode, entry_address, entry_red, entry_green, entry_blue,
               pixel_red, pixel_green, pixel_blue,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_address, entry_red, entry_green, entry_blue,
               pixel_red, pixel_green, pixel_blue,
        output ready
    );
endinterface

interface hcl_out_if
    import hcl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) ();
    logic                     valid;
    logic                     ready;
    logic [FRACTION_BITS-1:0] out_red;
    logic [FRACTION_BITS-1:0] out_green;
    logic [FRACTION_BITS-1:0] out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

/* design/hald_clut_trilinear_lookup.sv */
// ----------------------------------------------------------------------------
// hald_clut_trilinear_lookup
// Hald color lookup table with trilinear interpolation.
// ----------------------------------------------------------------------------
// The block takes one transaction per cycle unless stalled, either a table
// write or a pixel, and returns one color per pixel through its stages:
// five index stages (clamp, scale, split, offsets, corner addresses), one
// table read stage and three blend stages. The cube is held in eight
// copies so that all eight corners are read in the same cycle; a write goes
// to all copies, so a pixel sees every write taken before it. The whole
// pipeline halts only while a finished color waits at the output.
module hald_clut_trilinear_lookup
    import hcl_pkg::*;
#(
    parameter int MAX_LEVEL     = MAX_LEVEL_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [LEVEL_BITS-1:0] cfg_data,
    hcl_in_if.sink                items,
    hcl_out_if.source             results
);
    localparam int DEPTH = MAX_LEVEL ** 6;
    localparam int AW    = $clog2(DEPTH);
    localparam int FB    = FRACTION_BITS;

    logic [LEVEL_BITS-1:0] lut_level_reg;
    logic                  adv;
    hcl_ctl_t              ctl;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;
    logic [AW-1:0]         rd_addr [CORNERS];
    logic [FB:0]           frac [3];
    logic [FB:0]           frac_m_reg [3];
    logic                  valid_m_reg;
    logic [ENTRY_BITS-1:0] corner [CORNERS];
    logic                  out_valid;
    logic [FB-1:0]         out_color [3];

    // Level register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            lut_level_reg <= LEVEL_BITS'(LEVEL_RESET);
        else if (cfg_write)
            lut_level_reg <= cfg_data;
    end

    // Every stage moves unless a result is held at the output.
    assign adv         = !out_valid || results.ready;
    assign items.ready = adv;

    hcl_index #(
        .MAX_LEVEL     (MAX_LEVEL),
        .FRACTION_BITS (FRACTION_BITS),
        .AW            (AW)
    ) u_index (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (adv),
        .in_valid      (items.valid),
        .mode          (items.mode),
        .entry_address (items.entry_address),
        .entry_red     (items.entry_red),
        .entry_green   (items.entry_green),
        .entry_blue    (items.entry_blue),
        .pixel_red     (items.pixel_red),
        .pixel_green   (items.pixel_green),
        .pixel_blue    (items.pixel_blue),
        .lut_level     (lut_level_reg),
        .ctl           (ctl),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .frac          (frac)
    );

    // Table copies, one per corner.
    for (genvar k = 0; k < CORNERS; k++)
    begin : g_bank
        hcl_cube_bank #(
            .AW    (AW),
            .DEPTH (DEPTH)
        ) u_bank (
            .clk   (clk),
            .en    (adv),
            .we    (ctl.write),
            .waddr (wr_addr),
            .wdata (wr_data),
            .raddr (rd_addr[k]),
            .rdata (corner[k])
        );
    end

    // Read stage valid bit and fractions.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_m_reg <= 1'b0;
        else if (adv)
            valid_m_reg <= ctl.pixel;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            frac_m_reg <= frac;
    end

    hcl_blend #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_m_reg),
        .corner    (corner),
        .frac      (frac_m_reg),
        .out_valid (out_valid),
        .out_color (out_color)
    );

    assign results.valid     = out_valid;
    assign results.out_red   = out_color[0];
    assign results.out_green = out_color[1];
    assign results.out_blue  = out_color[2];

    // A slot is never both a pixel and a write.
    a_ctl_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.pixel && ctl.write))
        else $error("pipeline slot marked as pixel and write");

    // Fractions never exceed one.
    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.pixel |-> (frac[0] <= ((FB + 1)'(1) << FB)) && (frac[1] <= ((FB + 1)'(1) << FB))
                      && (frac[2] <= ((FB + 1)'(1) << FB)))
        else $error("cell fraction above one");

    // A stall freezes the read stage and the output valid bit.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_m_reg) && $stable(out_valid))
        else $error("pipeline moved during a stall");

endmodule

/* design/hcl_index.sv */
// ----------------------------------------------------------------------------
// hcl_index
// Clamps and scales the pixel, splits it into cell and fraction and forms
// the eight corner addresses; table writes travel along the same stages.
// ----------------------------------------------------------------------------
module hcl_index
    import hcl_pkg::*;
#(
    parameter int MAX_LEVEL     = MAX_LEVEL_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    parameter int AW            = 18
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            mode,
    input  logic [ADDR_BITS-1:0]            entry_address,
    input  logic [BYTE_BITS-1:0]            entry_red,
    input  logic [BYTE_BITS-1:0]            entry_green,
    input  logic [BYTE_BITS-1:0]            entry_blue,
    input  logic signed [FRACTION_BITS+1:0] pixel_red,
    input  logic signed [FRACTION_BITS+1:0] pixel_green,
    input  logic signed [FRACTION_BITS+1:0] pixel_blue,
    input  logic [LEVEL_BITS-1:0]           lut_level,
    output hcl_ctl_t                        ctl,
    output logic [AW-1:0]                   wr_addr,
    output logic [ENTRY_BITS-1:0]           wr_data,
    output logic [AW-1:0]                   rd_addr [CORNERS],
    output logic [FRACTION_BITS:0]          frac [3]
);
    localparam int FB    = FRACTION_BITS;
    localparam int PB    = FB + 2;
    localparam int XB    = FB + 1;
    localparam int DEPTH = MAX_LEVEL ** 6;
    localparam int NB    = $clog2(MAX_LEVEL * MAX_LEVEL + 1);
    localparam int NNB   = $clog2(MAX_LEVEL ** 4 + 1);
    localparam int IB    = $clog2(MAX_LEVEL * MAX_LEVEL);
    localparam int SB    = XB + NB;
    localparam logic [PB-1:0] ONE_P = PB'(1) << FB;

    logic signed [PB-1:0] pix [3];
    logic [LEVEL_EXT_BITS-1:0] lvl;
    logic [XB-1:0] x_next [3];

    // Stage 1 registers: clamped samples, cell count, write fields.
    hcl_ctl_t              c1_reg, c1_next;
    logic [XB-1:0]         x1_reg [3];
    logic [NB-1:0]         n1_reg;
    logic [AW-1:0]         wa1_reg;
    logic [ENTRY_BITS-1:0] wd1_reg;
    // Stage 2: scaled samples.
    hcl_ctl_t              c2_reg;
    logic [SB-1:0]         s2_reg [3];
    logic [NB-1:0]         n2_reg;
    logic [NNB-1:0]        nn2_reg;
    logic [AW-1:0]         wa2_reg;
    logic [ENTRY_BITS-1:0] wd2_reg;
    // Stage 3: cell index and fraction.
    hcl_ctl_t              c3_reg;
    logic [IB-1:0]         i3_reg [3];
    logic [XB-1:0]         f3_reg [3];
    logic [NB-1:0]         n3_reg;
    logic [NNB-1:0]        nn3_reg;
    logic [AW-1:0]         wa3_reg;
    logic [ENTRY_BITS-1:0] wd3_reg;
    logic [IB-1:0]         i3_next [3];
    logic [XB-1:0]         f3_next [3];
    // Stage 4: row and plane offsets.
    hcl_ctl_t              c4_reg;
    logic [AW-1:0]         t0_4_reg, t1_4_reg, t2_4_reg;
    logic [XB-1:0]         f4_reg [3];
    logic [NB-1:0]         n4_reg;
    logic [NNB-1:0]        nn4_reg;
    logic [AW-1:0]         wa4_reg;
    logic [ENTRY_BITS-1:0] wd4_reg;
    // Stage 5: corner addresses.
    hcl_ctl_t              c5_reg;
    logic [AW-1:0]         ra5_reg [CORNERS];
    logic [AW-1:0]         ra5_next [CORNERS];
    logic [XB-1:0]         f5_reg [3];
    logic [AW-1:0]         wa5_reg;
    logic [ENTRY_BITS-1:0] wd5_reg;
    logic [AW-1:0]         base;

    assign pix[0] = pixel_red;
    assign pix[1] = pixel_green;
    assign pix[2] = pixel_blue;

    // Effective level and clamped samples ahead of stage 1.
    always_comb
    begin
        if (lut_level < LEVEL_BITS'(LEVEL_MIN))
            lvl = LEVEL_EXT_BITS'(LEVEL_MIN);
        else if (LEVEL_EXT_BITS'(lut_level) > LEVEL_EXT_BITS'(MAX_LEVEL))
            lvl = LEVEL_EXT_BITS'(MAX_LEVEL);
        else
            lvl = LEVEL_EXT_BITS'(lut_level);
        for (int c = 0; c < 3; c++)
        begin
            if (pix[c][PB-1])
                x_next[c] = '0;
            else if ($unsigned(pix[c]) > ONE_P)
                x_next[c] = XB'(ONE_P);
            else
                x_next[c] = pix[c][XB-1:0];
        end
        c1_next.pixel = in_valid && (mode == MODE_PIXEL);
        c1_next.write = in_valid && (mode == MODE_WRITE) && (int'(entry_address) < DEPTH);
    end

    // Stage 3 split: integer part clamped to N-2, the rest is the fraction.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if ((s2_reg[c] >> FB) > SB'(n2_reg - NB'(2)))
                i3_next[c] = IB'(n2_reg - NB'(2));
            else
                i3_next[c] = IB'(s2_reg[c] >> FB);
            f3_next[c] = XB'(s2_reg[c] - (SB'(i3_next[c]) << FB));
        end
    end

    // Stage 5 corner addresses: bit 0 steps red, bit 1 green, bit 2 blue.
    always_comb
    begin
        base = t0_4_reg + t1_4_reg + t2_4_reg;
        for (int k = 0; k < CORNERS; k++)
        begin
            ra5_next[k] = base + AW'(k & 1)
                        + (((k & 2) != 0) ? AW'(n4_reg) : AW'(0))
                        + (((k & 4) != 0) ? AW'(nn4_reg) : AW'(0));
        end
    end

    // Control state of every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
            c4_reg <= c3_reg;
            c5_reg <= c4_reg;
        end
    end

    // Payload of every stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x_next;
            n1_reg  <= NB'(lvl * lvl);
            wa1_reg <= AW'(entry_address);
            wd1_reg <= {entry_blue, entry_green, entry_red};

            for (int c = 0; c < 3; c++)
                s2_reg[c] <= SB'(x1_reg[c] * (n1_reg - NB'(1)));
            n2_reg  <= n1_reg;
            nn2_reg <= NNB'(n1_reg * n1_reg);
            wa2_reg <= wa1_reg;
            wd2_reg <= wd1_reg;

            i3_reg  <= i3_next;
            f3_reg  <= f3_next;
            n3_reg  <= n2_reg;
            nn3_reg <= nn2_reg;
            wa3_reg <= wa2_reg;
            wd3_reg <= wd2_reg;

            t0_4_reg <= AW'(i3_reg[0]);
            t1_4_reg <= AW'(i3_reg[1] * n3_reg);
            t2_4_reg <= AW'(i3_reg[2] * nn3_reg);
            f4_reg   <= f3_reg;
            n4_reg   <= n3_reg;
            nn4_reg  <= nn3_reg;
            wa4_reg  <= wa3_reg;
            wd4_reg  <= wd3_reg;

            ra5_reg <= ra5_next;
            f5_reg  <= f4_reg;
            wa5_reg <= wa4_reg;
            wd5_reg <= wd4_reg;
        end
    end

    assign ctl     = c5_reg;
    assign rd_addr = ra5_reg;
    assign frac    = f5_reg;
    assign wr_addr = wa5_reg;
    assign wr_data = wd5_reg;

endmodule

/* design/hcl_cube_bank.sv */
// ----------------------------------------------------------------------------
// hcl_cube_bank
// One copy of the color cube: one write port, one registered read port.
// ----------------------------------------------------------------------------
module hcl_cube_bank
    import hcl_pkg::*;
#(
    parameter int AW    = 18,
    parameter int DEPTH = 262144
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [ENTRY_BITS-1:0] wdata,
    input  logic [AW-1:0]         raddr,
    output logic [ENTRY_BITS-1:0] rdata
);
    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rdata_reg;

    // Write and read in the same stage; the read data holds while stalled.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
                mem[waddr] <= wdata;
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/hcl_blend.sv */
// ----------------------------------------------------------------------------
// hcl_blend
// Three blend stages: along red, then green, then blue.
// ----------------------------------------------------------------------------
module hcl_blend
    import hcl_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [ENTRY_BITS-1:0]    corner [CORNERS],
    input  logic [FRACTION_BITS:0]   frac [3],
    output logic                     out_valid,
    output logic [FRACTION_BITS-1:0] out_color [3]
);
    localparam int FB = FRACTION_BITS;
    localparam int PW = 2 * FB + 1;
    localparam logic [FB:0] ONE = (FB + 1)'(1) << FB;

    logic          vx_reg, vy_reg, vz_reg;
    logic [FB-1:0] x_reg [3][4];
    logic [FB-1:0] x_next [3][4];
    logic [FB-1:0] y_reg [3][2];
    logic [FB-1:0] y_next [3][2];
    logic [FB-1:0] z_reg [3];
    logic [FB-1:0] z_next [3];
    logic [FB:0]   fy_reg [2];
    logic [FB:0]   fz_reg;
    logic [FB-1:0] cv [3][CORNERS];

    // Weighted sum with each product truncated; never exceeds the larger input.
    function automatic logic [FB-1:0] mix(input logic [FB-1:0] a,
                                          input logic [FB-1:0] b,
                                          input logic [FB:0] t);
        logic [PW-1:0] pa;
        logic [PW-1:0] pb;
        pa = PW'(a * (ONE - t));
        pb = PW'(b * t);
        return FB'((pa >> FB) + (pb >> FB));
    endfunction

    // Table bytes scaled up to the fraction width.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
            for (int k = 0; k < CORNERS; k++)
                cv[c][k] = FB'(corner[k][c*BYTE_BITS +: BYTE_BITS]) << (FB - BYTE_BITS);
    end

    // Blend along each axis.
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            for (int j = 0; j < 4; j++)
                x_next[c][j] = mix(cv[c][2*j], cv[c][2*j+1], frac[0]);
            for (int j = 0; j < 2; j++)
                y_next[c][j] = mix(x_reg[c][2*j], x_reg[c][2*j+1], fy_reg[0]);
            z_next[c] = mix(y_reg[c][0], y_reg[c][1], fz_reg);
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vx_reg <= 1'b0;
            vy_reg <= 1'b0;
            vz_reg <= 1'b0;
        end
        else if (en)
        begin
            vx_reg <= in_valid;
            vy_reg <= vx_reg;
            vz_reg <= vy_reg;
        end
    end

    // Stage payload; the output register is the last stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg     <= x_next;
            fy_reg[0] <= frac[1];
            fy_reg[1] <= frac[2];
            y_reg     <= y_next;
            fz_reg    <= fy_reg[1];
            z_reg     <= z_next;
        end
    end

    assign out_valid = vz_reg;
    assign out_color = z_reg;

endmodule
